// ===== rtl/coincidence_event_qualifier_core_assert.svh =====
// Assertion macros shared by the coincidence event qualifier RTL.
`ifndef COINCIDENCE_EVENT_QUALIFIER_CORE_ASSERT_SVH
`define COINCIDENCE_EVENT_QUALIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CEQ_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked outside reset.
`define CEQ_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== rtl/ceq_pkg.sv =====
// Types, codes and constants shared by the coincidence event qualifier.
package ceq_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int WFB_DEF         = 16;

  localparam int ENERGY_W    = 12;
  localparam int WINDOW_W    = 17;
  localparam int HALF_LIFE_W = 40;
  localparam int TIME_W      = 48;
  localparam int TS_W        = 47;
  localparam int DIAM_W      = 16;
  localparam int DT_W        = 18;
  localparam int ANGLE_W     = 16;
  localparam int WEIGHT_W    = 41;
  localparam int WMAG_W      = 40;
  localparam int NET_W       = 48;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 4;

  // Exponent fraction bits and the serial units built around them.
  localparam int EXP_FRAC  = 30;
  localparam int DIV_NUM_W = TIME_W + EXP_FRAC;   // |ts - t0| < 2^48, then 30 fraction bits
  localparam int DIV_DEN_W = HALF_LIFE_W;
  localparam int ROOT_W    = 32;

  localparam logic [ENERGY_W-1:0]    ENERGY_LOW_RST  = 12'd350;
  localparam logic [ENERGY_W-1:0]    ENERGY_HIGH_RST = 12'd700;
  localparam logic [WINDOW_W-1:0]    WINDOW_RST      = 17'd20000;
  localparam logic [HALF_LIFE_W-1:0] HALF_LIFE_RST   = '0;
  localparam logic [TIME_W-1:0]      INIT_TIME_AUTO  = '1;
  localparam logic [DIAM_W-1:0]      DIAM_RST        = '0;

  localparam logic [DT_W-1:0]      DT_MAX_PS    = 18'd90000;
  localparam logic [DT_W-1:0]      DT_RAND_PS   = 18'd20000;
  localparam logic [DIV_DEN_W-1:0] RAND_SPAN_PS = 40'd70000;
  localparam logic [DIV_NUM_W-1:0] RAND_HALF_PS = 78'd35000;
  localparam logic [COUNT_W-1:0]   MAX_HITS     = 4'd2;

  localparam logic [WMAG_W-1:0] WEIGHT_MAX = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENERGY_LOW   = 3'd0,
    REG_ENERGY_HIGH  = 3'd1,
    REG_WINDOW       = 3'd2,
    REG_HALF_LIFE    = 3'd3,
    REG_INIT_TIME    = 3'd4,
    REG_DIAMETER     = 3'd5,
    REG_NO_DOI       = 3'd6,
    REG_DIRECT_CORR  = 3'd7
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROMPT = 3'd0,
    ST_RANDOM = 3'd1,
    ST_FOV    = 3'd2,
    ST_ENERGY = 3'd3,
    ST_TIME   = 3'd4,
    ST_HITS   = 3'd5
  } status_t;

endpackage

// ===== rtl/ceq_ifs.sv =====
// Channel interfaces of the coincidence event qualifier.
interface ceq_in_if import ceq_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] hit1_x;
  logic signed [COORD_WIDTH-1:0] hit1_y;
  logic signed [COORD_WIDTH-1:0] hit1_z;
  logic signed [COORD_WIDTH-1:0] hit2_x;
  logic signed [COORD_WIDTH-1:0] hit2_y;
  logic signed [COORD_WIDTH-1:0] hit2_z;
  logic [2*ENERGY_W-1:0]         energies;
  logic [2*COUNT_W-1:0]          hit_counts;
  logic signed [DT_W-1:0]        time_difference;
  logic [TS_W-1:0]               timestamp;
  logic [ANGLE_W-1:0]            angle_code;
  logic                          random_in;

  modport source (output valid, hit1_x, hit1_y, hit1_z, hit2_x, hit2_y, hit2_z, energies,
                  hit_counts, time_difference, timestamp, angle_code, random_in,
                  input ready);
  modport sink (input valid, hit1_x, hit1_y, hit1_z, hit2_x, hit2_y, hit2_z, energies,
                hit_counts, time_difference, timestamp, angle_code, random_in,
                output ready);
endinterface

interface ceq_out_if import ceq_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x1;
  logic signed [COORD_WIDTH-1:0] out_y1;
  logic signed [COORD_WIDTH-1:0] out_z1;
  logic signed [COORD_WIDTH-1:0] out_x2;
  logic signed [COORD_WIDTH-1:0] out_y2;
  logic signed [COORD_WIDTH-1:0] out_z2;
  logic [ANGLE_W-1:0]            out_angle;
  logic signed [WEIGHT_W-1:0]    event_weight;
  logic [STATUS_W-1:0]           status;
  logic                          to_main;
  logic signed [NET_W-1:0]       net_sum;

  modport source (output valid, out_x1, out_y1, out_z1, out_x2, out_y2, out_z2, out_angle,
                  event_weight, status, to_main, net_sum, input ready);
  modport sink (input valid, out_x1, out_y1, out_z1, out_x2, out_y2, out_z2, out_angle,
                event_weight, status, to_main, net_sum, output ready);
endinterface

interface ceq_cfg_if import ceq_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ceq_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ceq_sdiv import ceq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] nq;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dv;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  // The numerator register shifts out its top bit as quotient bits shift in.
  assign rem_sh  = {rem, nq[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dv};
  assign ge      = rem_sh >= {1'b0, dv};
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nq   <= num;
        rem  <= '0;
        dv   <= den;
      end else if (busy) begin
        nq  <= {nq[DIV_NUM_W-2:0], ge};
        rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ceq_pow2.sv =====
// Fractional power of two in Q2.30 by repeated square roots, two radicand bits per cycle.
module ceq_pow2 import ceq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [EXP_FRAC-1:0] frac,
  output logic                done,
  output logic [ROOT_W-1:0]   y
);

  localparam int K_W    = $clog2(EXP_FRAC);
  localparam int STEP_W = $clog2(ROOT_W);

  logic [EXP_FRAC-1:0] fr;
  logic [K_W-1:0]      k;
  logic [STEP_W-1:0]   step;
  logic                busy;
  logic                loading;
  logic [ROOT_W-1:0]   yv;
  logic [2*ROOT_W-1:0] vsh;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W:0]     m;
  logic [ROOT_W+3:0]   rem2;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   rdiff;
  logic                ge;
  logic [ROOT_W-1:0]   root_n;

  // Each pass takes the square root of y * 2^bit, scaled back into Q2.30.
  assign m      = fr[k] ? {yv, 1'b0} : {1'b0, yv};
  assign rem2   = {rem, vsh[2*ROOT_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign rdiff  = rem2 - trial;
  assign ge     = rem2 >= trial;
  assign root_n = {root[ROOT_W-2:0], ge};
  assign y      = yv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      loading <= 1'b0;
      k       <= '0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        loading <= 1'b1;
        k       <= '0;
        fr      <= frac;
        yv      <= ROOT_W'(1) << EXP_FRAC;
      end else if (busy) begin
        if (loading) begin
          vsh     <= {1'b0, m, {EXP_FRAC{1'b0}}};
          rem     <= '0;
          root    <= '0;
          step    <= '0;
          loading <= 1'b0;
        end else begin
          vsh  <= {vsh[2*ROOT_W-3:0], 2'b00};
          rem  <= ge ? rdiff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
          root <= root_n;
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) begin
            yv <= root_n;
            if (k == K_W'(EXP_FRAC - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              k       <= k + 1'b1;
              loading <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/coincidence_event_qualifier_core.sv =====
// Coincidence event qualifier: top level with control sequencer and datapath.
// Sequence: a rejected or undecayed prompt event passes the field of view steps and the
// classification; a random adds the serial weight divide; with decay correction on, the serial
// exponent divide, the 30 square roots of 2^frac, a multiply and a scale step follow.
// One event at a time; the next event is taken once the result is in the output register.
// Reset (rst, synchronous) restores register defaults, clears the running sum and t0 latch.
module coincidence_event_qualifier_core import ceq_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WFB_DEF
) (
  input logic    clk,
  input logic    rst,
  ceq_cfg_if.sink cfg,
  ceq_in_if.sink  evt,
  ceq_out_if.source res
);

  `include "coincidence_event_qualifier_core_assert.svh"

  // Weight magnitude before decay fits WEIGHT_FRAC_BITS + 2 bits; the product adds the root.
  localparam int W_W    = WEIGHT_FRAC_BITS + 2;
  localparam int PROD_W = W_W + ROOT_W;
  localparam int MW     = (COORD_WIDTH > DIAM_W) ? COORD_WIDTH : DIAM_W;
  localparam int AZW    = (COORD_WIDTH + 1 > DIAM_W + 1) ? COORD_WIDTH + 1 : DIAM_W + 1;
  localparam int SQ_W   = 17;
  localparam int SH_W   = 51;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FOV   = 9'b000000010,
    S_CLASS = 9'b000000100,
    S_WDIV  = 9'b000001000,
    S_DDIV  = 9'b000010000,
    S_POW   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [ENERGY_W-1:0]    energy_low, energy_high;
  logic [WINDOW_W-1:0]    window_ps;
  logic [HALF_LIFE_W-1:0] half_life_ms;
  logic [TIME_W-1:0]      initial_time;
  logic [DIAM_W-1:0]      detector_diameter;
  logic                   no_doi, direct_correction;

  // Persistent state.
  logic signed [TIME_W-1:0] start_time;
  logic                     start_known;
  logic signed [NET_W-1:0]  running_net;

  // Event held while it is worked on.
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;
  logic [ENERGY_W-1:0]           e1, e2;
  logic [COUNT_W-1:0]            n1, n2;
  logic signed [DT_W-1:0]        dt;
  logic [TS_W-1:0]               ts;
  logic [ANGLE_W-1:0]            angle;
  logic                          random;
  logic signed [TIME_W-1:0]      t0;

  // Field of view sequencing over one shared squarer.
  logic [2:0]        fstep;
  logic [SQ_W-1:0]   sq_op;
  logic [2*SQ_W-1:0] sq;
  logic [31:0]       dd;
  logic [2*SQ_W:0]   fov_acc;
  logic              fov_hit;

  // Decay path.
  logic signed [TIME_W:0]  diff_r;
  logic                    diff_neg;
  logic [TIME_W-1:0]       dabs;
  logic signed [SH_W-1:0]  s_amt;
  logic [W_W-1:0]          w;
  logic [PROD_W-1:0]       prod;
  logic [WMAG_W-1:0]       wmag;
  status_t                 cls;

  // Output register.
  logic                          ov;
  logic signed [COORD_WIDTH-1:0] o_x1, o_y1, o_z1, o_x2, o_y2, o_z2;
  logic [ANGLE_W-1:0]            o_angle;
  logic signed [WEIGHT_W-1:0]    o_weight;
  status_t                       o_status;
  logic                          o_main;

  logic acc_evt, out_free, init_auto;
  assign acc_evt   = evt.valid && evt.ready;
  assign out_free  = !ov || res.ready;
  assign init_auto = (initial_time == INIT_TIME_AUTO);
  assign evt.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Configuration writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_low        <= ENERGY_LOW_RST;
      energy_high       <= ENERGY_HIGH_RST;
      window_ps         <= WINDOW_RST;
      half_life_ms      <= HALF_LIFE_RST;
      initial_time      <= INIT_TIME_AUTO;
      detector_diameter <= DIAM_RST;
      no_doi            <= 1'b0;
      direct_correction <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_ENERGY_LOW:  energy_low        <= cfg.data[ENERGY_W-1:0];
        REG_ENERGY_HIGH: energy_high       <= cfg.data[ENERGY_W-1:0];
        REG_WINDOW:      window_ps         <= cfg.data[WINDOW_W-1:0];
        REG_HALF_LIFE:   half_life_ms      <= cfg.data[HALF_LIFE_W-1:0];
        REG_INIT_TIME:   initial_time      <= cfg.data[TIME_W-1:0];
        REG_DIAMETER:    detector_diameter <= cfg.data[DIAM_W-1:0];
        REG_NO_DOI:      no_doi            <= cfg.data[0];
        REG_DIRECT_CORR: direct_correction <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Depth snapping. The snapped magnitude is half the diameter, clipped to the coordinate
  // range; the field of view test instead uses the full diameter on the doubled depth.
  logic [MW-1:0]          d_half, cmax, magw;
  logic [COORD_WIDTH-1:0] mag;
  logic signed [COORD_WIDTH-1:0] z1s, z2s;
  assign d_half = MW'(detector_diameter[DIAM_W-1:1]);
  assign cmax   = MW'({(COORD_WIDTH-1){1'b1}});
  assign magw   = (d_half > cmax) ? cmax : d_half;
  assign mag    = magw[COORD_WIDTH-1:0];
  assign z1s    = no_doi ? (z1[COORD_WIDTH-1] ? -$signed(mag) : $signed(mag)) : z1;
  assign z2s    = no_doi ? (z2[COORD_WIDTH-1] ? -$signed(mag) : $signed(mag)) : z2;

  // Magnitudes for the field of view test. A hit beyond the tested range is never inside.
  logic [COORD_WIDTH-1:0] ay1, ay2, azc1, azc2;
  logic [AZW-1:0]         az1, az2;
  logic                   ok1, ok2;
  assign ay1  = y1[COORD_WIDTH-1] ? COORD_WIDTH'(-y1) : COORD_WIDTH'(y1);
  assign ay2  = y2[COORD_WIDTH-1] ? COORD_WIDTH'(-y2) : COORD_WIDTH'(y2);
  assign azc1 = z1[COORD_WIDTH-1] ? COORD_WIDTH'(-z1) : COORD_WIDTH'(z1);
  assign azc2 = z2[COORD_WIDTH-1] ? COORD_WIDTH'(-z2) : COORD_WIDTH'(z2);
  assign az1  = no_doi ? AZW'(detector_diameter) : AZW'({azc1, 1'b0});
  assign az2  = no_doi ? AZW'(detector_diameter) : AZW'({azc2, 1'b0});
  assign ok1  = (64'(ay1) < 64'd32768) && (64'(az1) < 64'd65536);
  assign ok2  = (64'(ay2) < 64'd32768) && (64'(az2) < 64'd65536);

  // One squarer serves the diameter and the four hit terms in turn.
  always_comb begin
    case (fstep)
      3'd0:    sq_op = SQ_W'(detector_diameter);
      3'd1:    sq_op = SQ_W'(ay1);
      3'd2:    sq_op = SQ_W'(az1);
      3'd3:    sq_op = SQ_W'(ay2);
      3'd4:    sq_op = SQ_W'(az2);
      default: sq_op = '0;
    endcase
  end

  logic [2*SQ_W:0] fov_sum;
  assign fov_sum = fov_acc + (2*SQ_W+1)'(sq);

  // Classification once the field of view result is in.
  logic [DT_W-1:0] dt_abs;
  logic            e_bad, dt_rand;
  status_t         cls_c;
  assign dt_abs  = dt[DT_W-1] ? DT_W'(-dt) : DT_W'(dt);
  assign e_bad   = (e1 < energy_low) || (e1 > energy_high) ||
                   (e2 < energy_low) || (e2 > energy_high);
  assign dt_rand = dt_abs > DT_RAND_PS;

  always_comb begin
    if (fov_hit) begin
      cls_c = ST_FOV;
    end else if (e_bad) begin
      cls_c = ST_ENERGY;
    end else if (dt_abs > DT_MAX_PS) begin
      cls_c = ST_TIME;
    end else if (!dt_rand && (dt_abs > DT_W'(window_ps))) begin
      cls_c = ST_TIME;
    end else if ((n1 > MAX_HITS) || (n2 > MAX_HITS)) begin
      cls_c = ST_HITS;
    end else begin
      cls_c = ST_PROMPT;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc_evt) state_next = S_FOV;
      S_FOV:   if (fstep == 3'd5) state_next = S_CLASS;
      S_CLASS: begin
        if (cls_c != ST_PROMPT) state_next = S_DONE;
        else if (dt_rand) state_next = S_WDIV;
        else if (half_life_ms == '0) state_next = S_DONE;
        else state_next = S_DDIV;
      end
      S_WDIV:  if (div_done) state_next = (half_life_ms == '0) ? S_DONE : S_DDIV;
      S_DDIV:  if (div_done) state_next = S_POW;
      S_POW:   if (pow_done) state_next = S_MUL;
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The shared serial divider forms the random weight window*2^F/70000 (rounded half up)
  // and then the decay exponent |ts - t0| / half_life with 30 fraction bits.
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  assign diff_neg  = diff_r[TIME_W];
  assign dabs      = diff_neg ? TIME_W'(-diff_r) : TIME_W'(diff_r);
  assign div_start = ((state_next == S_WDIV) && (state != S_WDIV)) ||
                     ((state_next == S_DDIV) && (state != S_DDIV));
  assign div_num   = (state_next == S_WDIV) ?
                     ((DIV_NUM_W'(window_ps) << WEIGHT_FRAC_BITS) + RAND_HALF_PS) :
                     {dabs, {EXP_FRAC{1'b0}}};
  assign div_den   = (state_next == S_WDIV) ? RAND_SPAN_PS : half_life_ms;

  ceq_sdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Exponent split: a negative exponent with a fraction borrows one from the integer part.
  logic [TIME_W-1:0]   iabs;
  logic [EXP_FRAC-1:0] fq, pow_frac;
  logic [SH_W-1:0]     iabs_e;
  logic signed [SH_W-1:0] s_c;
  assign iabs     = div_quo[DIV_NUM_W-1:EXP_FRAC];
  assign fq       = div_quo[EXP_FRAC-1:0];
  assign pow_frac = (diff_neg && (fq != '0)) ? EXP_FRAC'(-fq) : fq;
  assign iabs_e   = SH_W'(iabs);
  assign s_c      = diff_neg ? $signed(iabs_e + ((fq == '0) ? SH_W'(EXP_FRAC) :
                                                 SH_W'(EXP_FRAC + 1))) :
                               $signed(SH_W'(EXP_FRAC) - iabs_e);

  logic              pow_start, pow_done;
  logic [ROOT_W-1:0] pow_y;
  assign pow_start = (state == S_DDIV) && div_done;

  ceq_pow2 u_pow (
    .clk   (clk),
    .rst   (rst),
    .start (pow_start),
    .frac  (pow_frac),
    .done  (pow_done),
    .y     (pow_y)
  );

  // Final scaling by 2^-s: rounding right shift, or a checked left shift that saturates.
  logic              s_neg, s_pos;
  logic [SH_W-1:0]   l_amt;
  logic [5:0]        rsh, lsh;
  logic [PROD_W-1:0] t_sh;
  logic [PROD_W:0]   t_rnd;
  logic [WMAG_W-1:0] scaled;
  assign s_neg = s_amt[SH_W-1];
  assign s_pos = !s_neg && (s_amt != '0);
  assign l_amt = SH_W'(-s_amt);
  assign rsh   = 6'(s_amt - 1);
  assign lsh   = 6'(l_amt);
  assign t_sh  = prod >> rsh;
  assign t_rnd = ((PROD_W+1)'(t_sh) + 1'b1) >> 1;

  always_comb begin
    if (s_pos) begin
      if (s_amt >= SH_W'(60)) scaled = '0;
      else if (t_rnd > (PROD_W+1)'(WEIGHT_MAX)) scaled = WEIGHT_MAX;
      else scaled = WMAG_W'(t_rnd);
    end else if (prod == '0) begin
      scaled = '0;
    end else if (l_amt >= SH_W'(WMAG_W + 1)) begin
      scaled = WEIGHT_MAX;
    end else if ((prod >> (6'(WMAG_W) - lsh)) != '0) begin
      scaled = WEIGHT_MAX;
    end else begin
      scaled = WMAG_W'(prod << lsh);
    end
  end

  // Running sum, saturating on signed overflow of the 48 bit range.
  logic signed [NET_W:0] net_wide;
  logic signed [NET_W-1:0] net_next;
  assign net_wide = random ? ({running_net[NET_W-1], running_net} - (NET_W+1)'(wmag)) :
                             ({running_net[NET_W-1], running_net} + (NET_W+1)'(wmag));
  always_comb begin
    if (net_wide[NET_W] != net_wide[NET_W-1]) begin
      net_next = random ? {1'b1, {(NET_W-1){1'b0}}} : {1'b0, {(NET_W-1){1'b1}}};
    end else begin
      net_next = net_wide[NET_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fstep       <= '0;
      start_time  <= '0;
      start_known <= 1'b0;
      running_net <= '0;
      ov          <= 1'b0;
    end else begin
      state <= state_next;
      fstep <= (state == S_FOV) ? fstep + 1'b1 : '0;
      // Without a configured t0 the first event after reset sets it, rejected or not.
      if (acc_evt && init_auto && !start_known) begin
        start_time  <= $signed({1'b0, evt.timestamp});
        start_known <= 1'b1;
      end
      if (res.valid && res.ready) ov <= 1'b0;
      if ((state == S_DONE) && out_free) begin
        ov <= 1'b1;
        if (cls == ST_PROMPT) running_net <= net_next;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (acc_evt) begin
      x1     <= evt.hit1_x;
      y1     <= evt.hit1_y;
      z1     <= evt.hit1_z;
      x2     <= evt.hit2_x;
      y2     <= evt.hit2_y;
      z2     <= evt.hit2_z;
      e1     <= evt.energies[ENERGY_W-1:0];
      e2     <= evt.energies[2*ENERGY_W-1:ENERGY_W];
      n1     <= evt.hit_counts[COUNT_W-1:0];
      n2     <= evt.hit_counts[2*COUNT_W-1:COUNT_W];
      dt     <= evt.time_difference;
      ts     <= evt.timestamp;
      angle  <= evt.angle_code;
      random <= evt.random_in;
      if (!init_auto) t0 <= $signed(initial_time);
      else if (!start_known) t0 <= $signed({1'b0, evt.timestamp});
      else t0 <= start_time;
    end
    if (state == S_FOV) begin
      sq     <= sq_op * sq_op;
      diff_r <= $signed({2'b00, ts}) - $signed({t0[TIME_W-1], t0});
      case (fstep)
        3'd1:    dd <= sq[31:0];
        3'd2:    fov_acc <= (2*SQ_W+1)'(sq) << 2;
        3'd3:    fov_hit <= ok1 && (fov_sum < (2*SQ_W+1)'(dd));
        3'd4:    fov_acc <= (2*SQ_W+1)'(sq) << 2;
        3'd5:    fov_hit <= fov_hit || (ok2 && (fov_sum < (2*SQ_W+1)'(dd)));
        default: ;
      endcase
    end
    if (state == S_CLASS) begin
      cls  <= cls_c;
      w    <= W_W'(1) << WEIGHT_FRAC_BITS;
      wmag <= WMAG_W'(W_W'(1) << WEIGHT_FRAC_BITS);
      if (cls_c == ST_PROMPT && dt_rand) random <= 1'b1;
    end
    if ((state == S_WDIV) && div_done) begin
      w    <= W_W'(div_quo);
      wmag <= WMAG_W'(W_W'(div_quo));
    end
    if ((state == S_DDIV) && div_done) s_amt <= s_c;
    if (state == S_MUL) prod <= PROD_W'(w) * PROD_W'(pow_y);
    if (state == S_SCALE) wmag <= scaled;
    if ((state == S_DONE) && out_free) begin
      o_x1    <= x1;
      o_y1    <= y1;
      o_z1    <= z1s;
      o_x2    <= x2;
      o_y2    <= y2;
      o_z2    <= z2s;
      o_angle <= angle;
      if (cls == ST_PROMPT) begin
        o_status <= random ? ST_RANDOM : ST_PROMPT;
        o_main   <= !random || direct_correction;
        o_weight <= random ? -$signed(WEIGHT_W'(wmag)) : $signed(WEIGHT_W'(wmag));
      end else begin
        o_status <= cls;
        o_main   <= 1'b0;
        o_weight <= '0;
      end
    end
  end

  // Result channel. The sum reported is the one after this event.
  assign res.valid        = ov;
  assign res.out_x1       = o_x1;
  assign res.out_y1       = o_y1;
  assign res.out_z1       = o_z1;
  assign res.out_x2       = o_x2;
  assign res.out_y2       = o_y2;
  assign res.out_z2       = o_z2;
  assign res.out_angle    = o_angle;
  assign res.event_weight = o_weight;
  assign res.status       = o_status;
  assign res.to_main      = o_main;
  assign res.net_sum      = running_net;

  // An accepted transaction keeps the input closed for at least the following cycle.
  `CEQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, evt.valid && evt.ready, !evt.ready)
  // Rejected events carry no weight and never go to the main list.
  `CEQ_ASSERT_IMPLY(a_reject_zero, clk, rst, res.valid && (res.status == ST_FOV || res.status == ST_ENERGY || res.status == ST_TIME || res.status == ST_HITS), res.event_weight == '0 && !res.to_main)
  // Prompts are non-negative and always go to the main list.
  `CEQ_ASSERT_IMPLY(a_prompt_main, clk, rst, res.valid && res.status == ST_PROMPT, !res.event_weight[WEIGHT_W-1] && res.to_main)
  // Randoms are never positive.
  `CEQ_ASSERT_IMPLY(a_random_sign, clk, rst, res.valid && res.status == ST_RANDOM, res.event_weight[WEIGHT_W-1] || res.event_weight == '0)

endmodule
